[rtl/tsp_pkg.sv]
// Shared types, widths and constants of the triplanar texture sampler.
`timescale 1ns / 1ps
`default_nettype none

package tsp_pkg;

   localparam int TSP_MAX_TEX_DIM     = 256;
   localparam int TSP_COORD_FRAC_BITS = 16;

   localparam int ADDR_W      = 16;
   localparam int TEXEL_W     = 24;
   localparam int DIM_W       = 9;
   localparam int SCALE_W     = 24;
   localparam int MAG_W       = 16;
   localparam int SUM_W       = 17;
   localparam int SAMPLE_W    = 24;
   localparam int SAMPLE_FRAC = 16;
   localparam int QUO_W       = 8;
   localparam int NUM_W       = 42;
   localparam int BILERP_LAT  = 2;
   localparam int DIV_LAT     = QUO_W + 1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_TEX_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UV_SCALE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AVG_RED    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AVG_GREEN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_AVG_BLUE   = 3'd5;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd22938;
   localparam logic [7:0]         AVG_RESET   = 8'd128;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [15:0]       texel_index;
      logic [7:0]        texel_red;
      logic [7:0]        texel_green;
      logic [7:0]        texel_blue;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
   } tsp_req_type;

   typedef struct packed {
      logic [7:0] color_red;
      logic [7:0] color_green;
      logic [7:0] color_blue;
      logic       used_fallback;
   } tsp_rsp_type;

   typedef struct packed {
      logic [MAG_W-1:0] wx;
      logic [MAG_W-1:0] wy;
      logic [MAG_W-1:0] wz;
      logic [SUM_W-1:0] sum;
   } tsp_wgt_type;

endpackage

`default_nettype wire

[rtl/triplanar_bilinear_texture_sampler_top.sv]
// Top level of the triplanar bilinear texture sampler.
//
//   Port group | Direction | Handshake          | Moves
//   req_*      | in        | req_valid/req_ready | one write or sample item
//   rsp_*      | out       | rsp_valid/rsp_ready | one color per sample item
//   csr_*      | in        | csr_we              | one register write
//
// One item enters per cycle while a stall on rsp_ready does not hold the pipeline. A sample
// result is registered at the end of a pipeline that holds the bilinear multipliers and the nine-stage divider.
// Each of the twelve texel reads uses its own copy of the texel memory.
// Reset clears the valid bits and returns the configuration to its defaults; texel memory is not cleared.
// A stall on rsp_ready freezes the whole pipeline; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module triplanar_bilinear_texture_sampler_top #(
   parameter int MAX_TEX_DIM     = tsp_pkg::TSP_MAX_TEX_DIM,
   parameter int COORD_FRAC_BITS = tsp_pkg::TSP_COORD_FRAC_BITS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire tsp_pkg::tsp_req_type             req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output tsp_pkg::tsp_rsp_type                  rsp_data,
   input  wire logic                             csr_we,
   input  wire logic [tsp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tsp_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tsp_pkg::*;

   localparam int F    = COORD_FRAC_BITS;
   localparam int P_W  = F + DIM_W;
   localparam int TAIL = 1 + BILERP_LAT + DIV_LAT;

   typedef struct packed {
      logic [ADDR_W-1:0]  index;
      logic [TEXEL_W-1:0] data;
   } wr_type;

   typedef struct packed {
      logic [DIM_W-1:0] pos;
      logic [F-1:0]     frac;
   } axis_type;

   // Configuration registers.
   logic [DIM_W-1:0]   csr_width_ff, csr_height_ff;
   logic [SCALE_W-1:0] csr_scale_ff;
   logic [7:0]         csr_red_ff, csr_green_ff, csr_blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_width_ff  <= '0;
         csr_height_ff <= '0;
         csr_scale_ff  <= SCALE_RESET;
         csr_red_ff    <= AVG_RESET;
         csr_green_ff  <= AVG_RESET;
         csr_blue_ff   <= AVG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TEX_WIDTH:  csr_width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_TEX_HEIGHT: csr_height_ff <= csr_wdata[DIM_W-1:0];
            CSR_UV_SCALE:   csr_scale_ff  <= csr_wdata[SCALE_W-1:0];
            CSR_AVG_RED:    csr_red_ff    <= csr_wdata[7:0];
            CSR_AVG_GREEN:  csr_green_ff  <= csr_wdata[7:0];
            CSR_AVG_BLUE:   csr_blue_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   logic [DIM_W-1:0] wsat, hsat, wm1, hm1;
   assign wsat = (32'(csr_width_ff) > MAX_TEX_DIM) ? DIM_W'(MAX_TEX_DIM) : csr_width_ff;
   assign hsat = (32'(csr_height_ff) > MAX_TEX_DIM) ? DIM_W'(MAX_TEX_DIM) : csr_height_ff;
   assign wm1  = wsat - DIM_W'(1);
   assign hm1  = hsat - DIM_W'(1);

   logic pipe_en;
   assign pipe_en   = !rsp_valid || rsp_ready;
   assign req_ready = pipe_en;

   // Stage 1: accepted item.
   logic        s1_vld_ff;
   tsp_req_type s1_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_req_ff <= req_data;
      end
   end

   // Stage 2: wrapped coordinates and weights.
   logic [31:0]      prod_x, prod_y, prod_z;
   logic [MAG_W-1:0] mag_x, mag_y, mag_z;
   logic [SUM_W-1:0] mag_sum;
   tsp_wgt_type      s2_wgt_in;

   assign prod_x = 32'($unsigned(s1_req_ff.pos_x) * csr_scale_ff);
   assign prod_y = 32'($unsigned(s1_req_ff.pos_y) * csr_scale_ff);
   assign prod_z = 32'($unsigned(s1_req_ff.pos_z) * csr_scale_ff);

   assign mag_x = s1_req_ff.normal_x[15] ? MAG_W'(~s1_req_ff.normal_x + 16'sd1)
                                         : MAG_W'(s1_req_ff.normal_x);
   assign mag_y = s1_req_ff.normal_y[15] ? MAG_W'(~s1_req_ff.normal_y + 16'sd1)
                                         : MAG_W'(s1_req_ff.normal_y);
   assign mag_z = s1_req_ff.normal_z[15] ? MAG_W'(~s1_req_ff.normal_z + 16'sd1)
                                         : MAG_W'(s1_req_ff.normal_z);
   assign mag_sum = SUM_W'(mag_x) + SUM_W'(mag_y) + SUM_W'(mag_z);

   // A zero normal is treated as pointing straight up.
   always_comb begin
      s2_wgt_in.wx  = mag_x;
      s2_wgt_in.wy  = mag_y;
      s2_wgt_in.wz  = mag_z;
      s2_wgt_in.sum = mag_sum;
      if (mag_sum == '0) begin
         s2_wgt_in.wz  = MAG_W'(1);
         s2_wgt_in.sum = SUM_W'(1);
      end
   end

   logic        s2_vld_ff, s2_wr_ff, s2_fb_ff;
   logic [F-1:0] s2_ux_ff, s2_uy_ff, s2_uz_ff;
   tsp_wgt_type s2_wgt_ff;
   wr_type      s2_wrd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_wr_ff  <= s1_req_ff.cmd == CMD_WRITE;
         s2_fb_ff  <= (csr_width_ff == '0) || (csr_height_ff == '0);
         s2_ux_ff  <= prod_x[31 -: F];
         s2_uy_ff  <= prod_y[31 -: F];
         s2_uz_ff  <= prod_z[31 -: F];
         s2_wgt_ff <= s2_wgt_in;
         s2_wrd_ff <= '{index: s1_req_ff.texel_index,
                        data:  {s1_req_ff.texel_red, s1_req_ff.texel_green,
                                s1_req_ff.texel_blue}};
      end
   end

   // Stage 3: texel-space positions along each of the four scaled axes.
   // Axis 0 is u_x by width-1, 1 is u_y by width-1, 2 is u_y by height-1, 3 is u_z by height-1.
   logic [P_W-1:0] axp [4];
   assign axp[0] = P_W'(P_W'(s2_ux_ff) * P_W'(wm1));
   assign axp[1] = P_W'(P_W'(s2_uy_ff) * P_W'(wm1));
   assign axp[2] = P_W'(P_W'(s2_uy_ff) * P_W'(hm1));
   assign axp[3] = P_W'(P_W'(s2_uz_ff) * P_W'(hm1));

   logic        s3_vld_ff, s3_wr_ff, s3_fb_ff;
   axis_type    s3_ax_ff [4];
   tsp_wgt_type s3_wgt_ff;
   wr_type      s3_wrd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s3_wr_ff  <= s2_wr_ff;
         s3_fb_ff  <= s2_fb_ff;
         s3_wgt_ff <= s2_wgt_ff;
         s3_wrd_ff <= s2_wrd_ff;
         for (int a = 0; a < 4; a++) begin
            s3_ax_ff[a] <= '{pos: axp[a][P_W-1:F], frac: axp[a][F-1:0]};
         end
      end
   end

   // Stage 4: neighbor texels and memory addresses for the three planes.
   logic        s4_vld_ff, s4_wr_ff, s4_fb_ff;
   tsp_wgt_type s4_wgt_ff;
   wr_type      s4_wrd_ff;
   logic [3:0][ADDR_W-1:0] s4_addr_ff [3];
   logic [F-1:0] s4_fx_ff [3];
   logic [F-1:0] s4_fy_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (pipe_en) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s4_wr_ff  <= s3_wr_ff;
         s4_fb_ff  <= s3_fb_ff;
         s4_wgt_ff <= s3_wgt_ff;
         s4_wrd_ff <= s3_wrd_ff;
      end
   end

   for (genvar p = 0; p < 3; p++) begin : g_addr
      // Plane 0 is YZ, plane 1 is XZ, plane 2 is XY.
      localparam int XS = (p == 0) ? 1 : 0;
      localparam int YS = (p == 2) ? 2 : 3;

      logic [DIM_W-1:0]  x0, y0, x1, y1;
      logic [ADDR_W-1:0] row0, row1;
      logic [3:0][ADDR_W-1:0] addr_in;

      assign x0 = s3_ax_ff[XS].pos;
      assign y0 = s3_ax_ff[YS].pos;
      assign x1 = ((DIM_W+1)'(x0) + (DIM_W+1)'(1) < (DIM_W+1)'(wsat)) ? x0 + DIM_W'(1) : wm1;
      assign y1 = ((DIM_W+1)'(y0) + (DIM_W+1)'(1) < (DIM_W+1)'(hsat)) ? y0 + DIM_W'(1) : hm1;
      assign row0 = ADDR_W'(ADDR_W'(y0) * ADDR_W'(wsat));
      assign row1 = ADDR_W'(ADDR_W'(y1) * ADDR_W'(wsat));
      assign addr_in[0] = row0 + ADDR_W'(x0);
      assign addr_in[1] = row0 + ADDR_W'(x1);
      assign addr_in[2] = row1 + ADDR_W'(x0);
      assign addr_in[3] = row1 + ADDR_W'(x1);

      always_ff @(posedge clock) begin
         if (pipe_en) begin
            s4_addr_ff[p] <= addr_in;
            s4_fx_ff[p]   <= s3_ax_ff[XS].frac;
            s4_fy_ff[p]   <= s3_ax_ff[YS].frac;
         end
      end
   end

   // Stage 5: texel reads. Every copy takes each write, so the twelve
   // lookups of one sample proceed in parallel.
   logic [3:0][TEXEL_W-1:0] plane_texels [3];
   logic ram_wr_en;
   assign ram_wr_en = pipe_en && s4_vld_ff && s4_wr_ff;

   for (genvar p = 0; p < 3; p++) begin : g_plane_ram
      for (genvar k = 0; k < 4; k++) begin : g_corner
         tsp_texel_ram u_ram (
            .clock   (clock),
            .wr_en   (ram_wr_en),
            .wr_addr (s4_wrd_ff.index),
            .wr_data (s4_wrd_ff.data),
            .rd_en   (pipe_en),
            .rd_addr (s4_addr_ff[p][k]),
            .rd_data (plane_texels[p][k])
         );
      end
   end

   logic [F-1:0] s5_fx_ff [3];
   logic [F-1:0] s5_fy_ff [3];
   tsp_wgt_type  s5_wgt_ff, s6_wgt_ff, s7_wgt_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s5_fx_ff  <= s4_fx_ff;
         s5_fy_ff  <= s4_fy_ff;
         s5_wgt_ff <= s4_wgt_ff;
         s6_wgt_ff <= s5_wgt_ff;
         s7_wgt_ff <= s6_wgt_ff;
      end
   end

   // Stages 6 and 7: bilinear filtering per plane.
   logic [2:0][SAMPLE_W-1:0] plane_samples [3];

   for (genvar p = 0; p < 3; p++) begin : g_bilerp
      tsp_bilerp #(
         .COORD_FRAC_BITS (COORD_FRAC_BITS)
      ) u_bilerp (
         .clock   (clock),
         .en      (pipe_en),
         .texels  (plane_texels[p]),
         .frac_x  (s5_fx_ff[p]),
         .frac_y  (s5_fy_ff[p]),
         .samples (plane_samples[p])
      );
   end

   // Stages 8 to 16: weighted sum with half-step rounding, then division.
   logic [QUO_W-1:0] quo [3];

   for (genvar c = 0; c < 3; c++) begin : g_blend
      logic [NUM_W-1:0] num;

      assign num = NUM_W'(plane_samples[0][c]) * NUM_W'(s7_wgt_ff.wx)
                 + NUM_W'(plane_samples[1][c]) * NUM_W'(s7_wgt_ff.wy)
                 + NUM_W'(plane_samples[2][c]) * NUM_W'(s7_wgt_ff.wz)
                 + (NUM_W'(s7_wgt_ff.sum) << (SAMPLE_FRAC - 1));

      tsp_divider u_div (
         .clock (clock),
         .en    (pipe_en),
         .num   (num),
         .den   (s7_wgt_ff.sum),
         .quo   (quo[c])
      );
   end

   // Sample and fallback flags travel alongside the data from stage 5 on.
   logic [TAIL-1:0] tail_vld_ff, tail_fb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_vld_ff <= '0;
      end else if (pipe_en) begin
         tail_vld_ff <= {tail_vld_ff[TAIL-2:0], s4_vld_ff && !s4_wr_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         tail_fb_ff <= {tail_fb_ff[TAIL-2:0], s4_fb_ff};
      end
   end

   // Stage 17: result register.
   logic        rsp_valid_ff;
   tsp_rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      if (tail_fb_ff[TAIL-1]) begin
         rsp_data_in = '{color_red: csr_red_ff, color_green: csr_green_ff,
                         color_blue: csr_blue_ff, used_fallback: 1'b1};
      end else begin
         rsp_data_in = '{color_red: quo[0], color_green: quo[1],
                         color_blue: quo[2], used_fallback: 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= tail_vld_ff[TAIL-1];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/tsp_texel_ram.sv]
// One copy of the texel memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tsp_texel_ram (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [tsp_pkg::ADDR_W-1:0]  wr_addr,
   input  wire logic [tsp_pkg::TEXEL_W-1:0] wr_data,
   input  wire logic                        rd_en,
   input  wire logic [tsp_pkg::ADDR_W-1:0]  rd_addr,
   output logic      [tsp_pkg::TEXEL_W-1:0] rd_data
);
   import tsp_pkg::*;

   logic [TEXEL_W-1:0] mem [2**ADDR_W];
   logic [TEXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/tsp_bilerp.sv]
// Two-stage bilinear filter of four RGB texels for one plane.
`timescale 1ns / 1ps
`default_nettype none

module tsp_bilerp #(
   parameter int COORD_FRAC_BITS = tsp_pkg::TSP_COORD_FRAC_BITS
) (
   input  wire logic                                   clock,
   input  wire logic                                   en,
   input  wire logic [3:0][tsp_pkg::TEXEL_W-1:0]       texels,
   input  wire logic [COORD_FRAC_BITS-1:0]             frac_x,
   input  wire logic [COORD_FRAC_BITS-1:0]             frac_y,
   output logic      [2:0][tsp_pkg::SAMPLE_W-1:0]      samples
);
   import tsp_pkg::*;

   localparam int F     = COORD_FRAC_BITS;
   localparam int TOP_W = 8 + F;
   localparam int VAL_W = 8 + 2 * F + 1;
   localparam int SH    = 2 * F - SAMPLE_FRAC;
   localparam logic [VAL_W-1:0] ROUND = (SH > 0) ? (VAL_W'(1) << (SH - 1)) : '0;
   localparam logic [F:0] ONE = (F+1)'(1) << F;

   logic [F:0]   wx0;
   logic [F:0]   wy0;
   logic [F-1:0] fy_ff;
   logic [2:0][TOP_W-1:0]    top_ff, bot_ff;
   logic [2:0][TOP_W-1:0]    top_in, bot_in;
   logic [2:0][SAMPLE_W-1:0] samples_ff, samples_in;

   assign wx0 = ONE - (F+1)'(frac_x);
   assign wy0 = ONE - (F+1)'(fy_ff);

   // Texel order is (x0,y0), (x1,y0), (x0,y1), (x1,y1); channel 0 is red.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         top_in[c] = TOP_W'(TOP_W'(texels[0][TEXEL_W-1-8*c -: 8]) * TOP_W'(wx0)
                          + TOP_W'(texels[1][TEXEL_W-1-8*c -: 8]) * TOP_W'(frac_x));
         bot_in[c] = TOP_W'(TOP_W'(texels[2][TEXEL_W-1-8*c -: 8]) * TOP_W'(wx0)
                          + TOP_W'(texels[3][TEXEL_W-1-8*c -: 8]) * TOP_W'(frac_x));
         samples_in[c] = SAMPLE_W'((VAL_W'(top_ff[c]) * VAL_W'(wy0)
                                  + VAL_W'(bot_ff[c]) * VAL_W'(fy_ff) + ROUND) >> SH);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         top_ff     <= top_in;
         bot_ff     <= bot_in;
         fy_ff      <= frac_y;
         samples_ff <= samples_in;
      end
   end

   assign samples = samples_ff;

endmodule

`default_nettype wire

[rtl/tsp_divider.sv]
// Pipelined restoring divider: rounded weighted sum over the weight total.
`timescale 1ns / 1ps
`default_nettype none

module tsp_divider (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire logic [tsp_pkg::NUM_W-1:0]   num,
   input  wire logic [tsp_pkg::SUM_W-1:0]   den,
   output logic      [tsp_pkg::QUO_W-1:0]   quo
);
   import tsp_pkg::*;

   // Stage zero holds the operands; each later stage settles one quotient bit.
   logic [NUM_W-1:0] rem_ff [QUO_W+1];
   logic [SUM_W-1:0] den_ff [QUO_W+1];
   logic [QUO_W-1:0] quo_ff [QUO_W+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num;
         den_ff[0] <= den;
         quo_ff[0] <= '0;
      end
   end

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      logic [NUM_W-1:0] trial;
      logic             fits;

      assign trial = NUM_W'({den_ff[j], {SAMPLE_FRAC{1'b0}}}) << (QUO_W - 1 - j);
      assign fits  = rem_ff[j] >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1] <= fits ? rem_ff[j] - trial : rem_ff[j];
            den_ff[j+1] <= den_ff[j];
            quo_ff[j+1] <= {quo_ff[j][QUO_W-2:0], fits};
         end
      end
   end

   assign quo = quo_ff[QUO_W];

endmodule

`default_nettype wire

[rtl/tsp_checker.sv]
// Port-level checks of the texture sampler, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module tsp_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire tsp_pkg::tsp_req_type           req_data,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire tsp_pkg::tsp_rsp_type           rsp_data,
   input  wire logic                           csr_we,
   input  wire logic [tsp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tsp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tsp_pkg::*;

   // A result waiting on the consumer holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // The input side only waits while a result is blocked at the output.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled with a free output");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

endmodule

bind triplanar_bilinear_texture_sampler_top tsp_checker u_tsp_checker (.*);

`default_nettype wire
